// ===== rtl/pmvs_pkg.sv =====
// shared types and constants for the pixel mean / variance statistics unit
package pmvs_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned CountW = 25;
  localparam int unsigned SumW   = 32;
  localparam int unsigned SqSumW = 40;
  localparam int unsigned MeanW  = 16;
  localparam int unsigned VarW   = 22;
  localparam int unsigned SdW    = 15;

  // shared adder and product width
  localparam int unsigned AluW = 64;
  // restoring divider: dividend, divisor / remainder, quotient
  localparam int unsigned DvdW = 80;
  localparam int unsigned RemW = 49;
  localparam int unsigned QuoW = 32;
  // quotient of the variance divide carries 16 fraction bits, the output keeps 8
  localparam int unsigned VarLsb = 8;
  localparam int unsigned IterW  = 7;

  localparam int unsigned MeanDivSteps = 40;
  localparam int unsigned VarDivSteps  = 80;
  localparam int unsigned SumMulSteps  = 32;
  localparam int unsigned CntMulSteps  = 25;
  localparam int unsigned SqrtSteps    = 16;

  localparam logic [CountW-1:0] MaxPixels  = 25'd16777216;
  localparam logic [QuoW-1:0]   SqrtTopBit = 32'h4000_0000;

  typedef struct packed {
    logic [PixW-1:0] pixel_value;
    logic            last_pixel;
  } pmvs_in_t;

  typedef struct packed {
    logic [MeanW-1:0]  mean_value;
    logic [VarW-1:0]   variance_value;
    logic [SdW-1:0]    std_dev_value;
    logic [CountW-1:0] pixel_total;
    logic              overflowed;
  } pmvs_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_MEAN,
    ST_MUL_SS,
    ST_MUL_NQ,
    ST_SUB,
    ST_MUL_NN,
    ST_DIV_VAR,
    ST_SQRT,
    ST_OUT
  } pmvs_state_e;

endpackage

// ===== rtl/pmvs_addsub.sv =====
// shared 64-bit add / subtract unit used by every iterative step
module pmvs_addsub (
  input  logic [pmvs_pkg::AluW-1:0] a_i,
  input  logic [pmvs_pkg::AluW-1:0] b_i,
  input  logic                      sub_i,
  output logic [pmvs_pkg::AluW-1:0] sum_o,
  output logic                      cout_o
);
  import pmvs_pkg::*;

  logic [AluW:0] total;

  // subtract as a + ~b + 1, carry out high means no borrow
  assign total  = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + (AluW + 1)'(sub_i);
  assign sum_o  = total[AluW-1:0];
  assign cout_o = total[AluW];

endmodule

// ===== rtl/pixel_mean_variance_stats_unit.sv =====
// top level: pixel accumulators and the sequencer for mean, variance and std deviation
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+-------------------------------------------
//  pixel in | item_i                    | taken on a clock edge with start && !busy
//  result   | result_o                  | valid for one cycle while done_o is high
//
// pixels are taken one per cycle while busy is low; a pixel with last_pixel set
// raises busy through prep, mean divide, two multiplies, subtract, a third multiply,
// variance divide, square root and the result state, all steps
// sharing one 64-bit adder, one bit per cycle
// rst_ni clears the accumulators and the sequencer asynchronously
// the result cannot be held off: done_o lasts one cycle, then busy drops
module pixel_mean_variance_stats_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  pmvs_pkg::pmvs_in_t  item_i,
  output logic                busy,
  output logic                done_o,
  output pmvs_pkg::pmvs_out_t result_o
);
  import pmvs_pkg::*;

  pmvs_state_e state_q, state_d;

  logic [CountW-1:0] count_q, count_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [SqSumW-1:0] sqsum_q, sqsum_d;
  logic              ovf_q, ovf_d;
  logic [IterW-1:0]  iter_q, iter_d;

  logic [AluW-1:0]   prod_q, prod_d;
  logic [AluW-1:0]   mcand_q, mcand_d;
  logic [SumW-1:0]   mplier_q, mplier_d;
  logic [AluW-1:0]   diff_q, diff_d;
  logic [DvdW-1:0]   dvd_q, dvd_d;
  logic [RemW-1:0]   dvs_q, dvs_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic [MeanW-1:0]  mean_q, mean_d;
  logic [QuoW-1:0]   sq_x_q, sq_x_d;
  logic [QuoW-1:0]   sq_res_q, sq_res_d;
  logic [QuoW-1:0]   sq_bit_q, sq_bit_d;

  logic [AluW-1:0]   alu_a, alu_b, alu_sum;
  logic              alu_sub, alu_cout;

  logic              accept;
  logic              last_step;
  logic [AluW-1:0]   prod_step;
  logic [RemW:0]     div_shift;
  logic [QuoW-1:0]   div_quo_next;
  logic [2*PixW-1:0] pix_sq;

  pmvs_addsub u_addsub (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sub_i  (alu_sub),
    .sum_o  (alu_sum),
    .cout_o (alu_cout)
  );

  assign accept       = start && !busy;
  assign last_step    = (iter_q == '0);
  assign prod_step    = mplier_q[0] ? alu_sum : prod_q;
  assign div_shift    = {rem_q, dvd_q[DvdW-1]};
  assign div_quo_next = {quo_q[QuoW-2:0], alu_cout};
  assign pix_sq       = (2*PixW)'(item_i.pixel_value) * (2*PixW)'(item_i.pixel_value);

  // sequencer
  always_comb begin
    state_d = state_q;
    busy    = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start && item_i.last_pixel) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP:     state_d = ST_DIV_MEAN;
      ST_DIV_MEAN: if (last_step) state_d = ST_MUL_SS;
      ST_MUL_SS:   if (last_step) state_d = ST_MUL_NQ;
      ST_MUL_NQ:   if (last_step) state_d = ST_SUB;
      ST_SUB:      state_d = ST_MUL_NN;
      ST_MUL_NN:   if (last_step) state_d = ST_DIV_VAR;
      ST_DIV_VAR:  if (last_step) state_d = ST_SQRT;
      ST_SQRT:     if (last_step) state_d = ST_OUT;
      ST_OUT: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath around the shared adder
  always_comb begin
    count_d  = count_q;
    sum_d    = sum_q;
    sqsum_d  = sqsum_q;
    ovf_d    = ovf_q;
    iter_d   = iter_q;
    prod_d   = prod_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    diff_d   = diff_q;
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    mean_d   = mean_q;
    sq_x_d   = sq_x_q;
    sq_res_d = sq_res_q;
    sq_bit_d = sq_bit_q;
    alu_a    = prod_q;
    alu_b    = mcand_q;
    alu_sub  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (count_q < MaxPixels) begin
            count_d = count_q + CountW'(1);
            sum_d   = sum_q + SumW'(item_i.pixel_value);
            sqsum_d = sqsum_q + SqSumW'(pix_sq);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      ST_PREP: begin
        // dividend left aligned so only the significant steps run
        dvd_d  = {sum_q, 8'b0, (DvdW - SumW - 8)'(0)};
        dvs_d  = RemW'(count_q);
        rem_d  = '0;
        iter_d = IterW'(MeanDivSteps - 1);
      end
      ST_DIV_MEAN, ST_DIV_VAR: begin
        alu_a   = AluW'(div_shift);
        alu_b   = AluW'(dvs_q);
        alu_sub = 1'b1;
        rem_d   = alu_cout ? alu_sum[RemW-1:0] : div_shift[RemW-1:0];
        quo_d   = div_quo_next;
        dvd_d   = dvd_q << 1;
        iter_d  = iter_q - IterW'(1);
        if (last_step) begin
          if (state_q == ST_DIV_MEAN) begin
            mean_d   = div_quo_next[MeanW-1:0];
            prod_d   = '0;
            mcand_d  = AluW'(sum_q);
            mplier_d = sum_q;
            iter_d   = IterW'(SumMulSteps - 1);
          end else begin
            sq_x_d   = div_quo_next;
            sq_res_d = '0;
            sq_bit_d = SqrtTopBit;
            iter_d   = IterW'(SqrtSteps - 1);
          end
        end
      end
      ST_MUL_SS, ST_MUL_NQ, ST_MUL_NN: begin
        prod_d   = prod_step;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        iter_d   = iter_q - IterW'(1);
        if (last_step) begin
          if (state_q == ST_MUL_SS) begin
            diff_d   = prod_step;
            prod_d   = '0;
            mcand_d  = AluW'(sqsum_q);
            mplier_d = SumW'(count_q);
            iter_d   = IterW'(CntMulSteps - 1);
          end else if (state_q == ST_MUL_NN) begin
            dvs_d  = prod_step[RemW-1:0];
            dvd_d  = {diff_q, (DvdW - AluW)'(0)};
            rem_d  = '0;
            iter_d = IterW'(VarDivSteps - 1);
          end
        end
      end
      ST_SUB: begin
        // N*Q - S^2, clamped at zero
        alu_a    = prod_q;
        alu_b    = diff_q;
        alu_sub  = 1'b1;
        diff_d   = alu_cout ? alu_sum : '0;
        prod_d   = '0;
        mcand_d  = AluW'(count_q);
        mplier_d = SumW'(count_q);
        iter_d   = IterW'(CntMulSteps - 1);
      end
      ST_SQRT: begin
        // res and bit never overlap, so or stands for the add
        alu_a   = AluW'(sq_x_q);
        alu_b   = AluW'(sq_res_q | sq_bit_q);
        alu_sub = 1'b1;
        if (alu_cout) begin
          sq_x_d   = alu_sum[QuoW-1:0];
          sq_res_d = (sq_res_q >> 1) | sq_bit_q;
        end else begin
          sq_res_d = sq_res_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
        iter_d   = iter_q - IterW'(1);
      end
      ST_OUT: begin
        count_d = '0;
        sum_d   = '0;
        sqsum_d = '0;
        ovf_d   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
      ovf_q   <= 1'b0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      sqsum_q <= sqsum_d;
      ovf_q   <= ovf_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    diff_q   <= diff_d;
    dvd_q    <= dvd_d;
    dvs_q    <= dvs_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    mean_q   <= mean_d;
    sq_x_q   <= sq_x_d;
    sq_res_q <= sq_res_d;
    sq_bit_q <= sq_bit_d;
  end

  assign result_o.mean_value     = mean_q;
  assign result_o.variance_value = quo_q[VarLsb +: VarW];
  assign result_o.std_dev_value  = sq_res_q[SdW-1:0];
  assign result_o.pixel_total    = count_q;
  assign result_o.overflowed     = ovf_q;

  // a marked pixel always starts a computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.last_pixel |=> busy)
    else $error("marked pixel did not start the computation");

  // after a result the unit takes pixels again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("unit stayed busy after a result");

  // the emitted root is the floor of the square root of the scaled variance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((64'(sq_res_q) * 64'(sq_res_q)) <= 64'(quo_q)) &&
               ((64'(sq_res_q) + 64'd1) * (64'(sq_res_q) + 64'd1) > 64'(quo_q)))
    else $error("square root out of range");

  // mean of 8-bit pixels cannot exceed 255.0, and a result always counts at least one pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.mean_value <= 16'hFF00) && (result_o.pixel_total != '0))
    else $error("mean or pixel count out of range");

endmodule

// ===== tb/sv/pixel_mean_variance_stats_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the pixel mean / variance statistics unit
module pixel_mean_variance_stats_unit_test;
  import pmvs_pkg::*;

  localparam int unsigned        ClkPeriod   = 12;
  localparam logic [24:0]        PixelLimit  = 25'd16777216;
  localparam int unsigned        DrainCycles = 300;
  localparam longint unsigned    CycleLimit  = 64'd2_000_000;
  localparam int unsigned        PhaseItems  = 350;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  pmvs_in_t  item_i = '0;
  logic      busy;
  logic      done_o;
  pmvs_out_t result_o;

  pixel_mean_variance_stats_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // pending pixels and the statistics expected for each finished image
  pmvs_in_t  pixel_q[$];
  pmvs_out_t stats_q[$];

  // shadow accumulators
  logic [24:0] acc_count;
  logic [31:0] acc_sum;
  logic [39:0] acc_sqsum;
  logic        acc_ovf;

  pmvs_in_t        held_px;
  pmvs_in_t        noise_px;
  logic            holding = 1'b0;
  logic            req_taken = 1'b0;
  int unsigned     idle_pct = 0;
  int unsigned     mismatches = 0;
  int unsigned     images_done = 0;
  longint unsigned pixels_taken = 0;
  longint unsigned cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d images still pending", cycles, stats_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] floor_root(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root[31:0];
  endfunction

  // mean, variance and std deviation of one image from its running sums
  function automatic pmvs_out_t image_stats(input logic [24:0] n, input logic [31:0] s,
                                            input logic [39:0] q, input logic ovf);
    pmvs_out_t    r;
    logic [63:0]  s64;
    logic [63:0]  n64;
    logic [63:0]  mean_q;
    logic [127:0] wn;
    logic [127:0] ws;
    logic [127:0] wq;
    logic [127:0] spread;
    logic [127:0] n_sq;
    logic [127:0] var_q;
    logic [127:0] root_arg;
    logic [31:0]  root;
    r = '0;
    r.pixel_total = n;
    r.overflowed  = ovf;
    if (n != '0) begin
      s64 = 64'(s);
      n64 = 64'(n);
      mean_q = (s64 << 8) / n64;
      wn = 128'(n);
      ws = 128'(s);
      wq = 128'(q);
      // spread = N*Q - S^2, clamped at zero
      spread = (wn * wq < ws * ws) ? '0 : wn * wq - ws * ws;
      n_sq = wn * wn;
      var_q = (spread << 8) / n_sq;
      root_arg = (spread << 16) / n_sq;
      root = floor_root(root_arg[63:0]);
      r.mean_value     = mean_q[15:0];
      r.variance_value = var_q[21:0];
      r.std_dev_value  = root[14:0];
    end
    return r;
  endfunction

  task automatic accumulate_pixel(input pmvs_in_t p);
    logic [15:0] sq_px;
    sq_px = 16'(p.pixel_value);
    sq_px = sq_px * sq_px;
    if (acc_count < PixelLimit) begin
      acc_count = acc_count + 25'd1;
      acc_sum   = acc_sum + 32'(p.pixel_value);
      acc_sqsum = acc_sqsum + 40'(sq_px);
    end else begin
      // accumulator full: pixel dropped
      acc_ovf = 1'b1;
    end
    if (p.last_pixel) begin
      stats_q.push_back(image_stats(acc_count, acc_sum, acc_sqsum, acc_ovf));
      acc_count = '0;
      acc_sum   = '0;
      acc_sqsum = '0;
      acc_ovf   = 1'b0;
    end
  endtask

  task automatic check_field(input string tag, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("image %0d %s: expected %0d, got %0d", images_done, tag, want, got);
    end
  endtask

  task automatic check_result(input pmvs_out_t got);
    pmvs_out_t want;
    if (stats_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result with no image pending: %p", got);
    end else begin
      want = stats_q.pop_front();
      check_field("mean", 32'(want.mean_value), 32'(got.mean_value));
      check_field("variance", 32'(want.variance_value), 32'(got.variance_value));
      check_field("std dev", 32'(want.std_dev_value), 32'(got.std_dev_value));
      check_field("pixel total", 32'(want.pixel_total), 32'(got.pixel_total));
      check_field("overflow", 32'(want.overflowed), 32'(got.overflowed));
    end
    images_done++;
  endtask

  // monitor: results first, then a request accepted on this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) check_result(result_o);
      if (start && !busy) begin
        req_taken = 1'b1;
        pixels_taken++;
        accumulate_pixel(item_i);
      end
    end
  end

  // driver: a request stays up until it is taken, noise on the bus while start is low
  always @(negedge clk_i) begin
    if (req_taken) begin
      req_taken = 1'b0;
      holding = 1'b0;
    end
    if (rst_ni && !holding && pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
      held_px = pixel_q.pop_front();
      holding = 1'b1;
    end
    noise_px.pixel_value = 8'($urandom);
    noise_px.last_pixel  = 1'($urandom);
    start  <= holding;
    item_i <= holding ? held_px : noise_px;
  end

  task automatic push_pixel(input logic [7:0] value, input logic last);
    pmvs_in_t p;
    p.pixel_value = value;
    p.last_pixel  = last;
    while (pixel_q.size() >= 8) @(posedge clk_i);
    pixel_q.push_back(p);
  endtask

  // style: 0 uniform, 1 biased to the extremes, 2 flat, 3 alternating black and white
  task automatic push_image(input int unsigned len, input int unsigned style);
    logic [7:0] flat;
    logic [7:0] value;
    flat = 8'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        0: value = 8'($urandom);
        1: begin
          case ($urandom_range(2))
            0: value = 8'd0;
            1: value = 8'd255;
            default: value = 8'($urandom);
          endcase
        end
        2: value = flat;
        default: value = i[0] ? 8'd255 : 8'd0;
      endcase
      push_pixel(value, i == len - 1);
    end
  endtask

  task automatic wait_sender_drained();
    while (pixel_q.size() != 0 || holding) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned phase_idle[3];
    phase_idle[0] = 0;
    phase_idle[1] = 85;
    phase_idle[2] = 36;
    acc_count = '0;
    acc_sum   = '0;
    acc_sqsum = '0;
    acc_ovf   = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: one-pixel images, widest spread, flat white, single bits
    idle_pct = 0;
    push_pixel(8'd0, 1'b1);
    push_pixel(8'd255, 1'b1);
    push_image(2, 3);
    for (int i = 0; i < 4; i++) push_pixel(8'd255, i == 3);
    push_image(6, 3);
    for (int b = 0; b < 8; b++) push_pixel(8'd1 << b, b == 7);
    wait_sender_drained();

    // random images, mostly short, through each idling phase
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = phase_idle[ph];
      sent = 0;
      while (sent < PhaseItems) begin
        len = ($urandom_range(15) == 0) ? $urandom_range(200, 17) : $urandom_range(16, 1);
        push_image(len, $urandom_range(3));
        sent += len;
      end
      wait_sender_drained();
    end

    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d pixels in %0d images checked against the expected statistics",
             pixels_taken, images_done);
    $display("sender idling phases of 0, 85 and 36 percent, %0d mismatches", mismatches);
    if (mismatches == 0 && stats_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pmvs_pkg.sv
rtl/pmvs_addsub.sv
rtl/pixel_mean_variance_stats_unit.sv
tb/sv/pixel_mean_variance_stats_unit_test.sv
